/* hdl/swvs_pkg.sv */
// ----------------------------------------------------------------------------
// swvs_pkg
// shared codes and widths for the square window value stamp block
// ----------------------------------------------------------------------------
package swvs_pkg;

  // request kinds
  typedef enum logic [1:0] {
    KIND_STAMP = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // configuration register indexes (byte address is four times the index)
  typedef enum logic [1:0] {
    REG_CENTER_SIZE = 2'd0,
    REG_MAP_WIDTH   = 2'd1,
    REG_MAP_HEIGHT  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  localparam int VAL_W    = 16;
  localparam int CSIZE_W  = 4;
  localparam int BOUND_W  = 7;
  localparam int INDEX_W  = 6;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  // signed window coordinate: index plus window offsets stays within 9 bits
  localparam int CRD_W    = 9;

  localparam logic [CSIZE_W-1:0] CENTER_SIZE_RST = 4'd3;
  localparam logic [BOUND_W-1:0] MAP_WIDTH_RST   = 7'd64;
  localparam logic [BOUND_W-1:0] MAP_HEIGHT_RST  = 7'd64;

endpackage

/* hdl/square_window_value_stamp_top.sv */
// ----------------------------------------------------------------------------
// square_window_value_stamp_top
// stamps positive pixel values over a square window of a map held in memory
// ----------------------------------------------------------------------------
// The map of MAP_COLS x MAP_ROWS 16-bit words sits in one simple
// dual-port style memory (one write and one registered read per cycle).
// One request is handled at a time. A stamp request with a positive value
// writes one map word per cycle over a c x c window, c being center_size
// limited to MAX_CENTER; a stamp with a non-positive value or c of zero,
// and an unused kind, leave the block idle. A read request passes through
// the registered memory read and then the load of the output register,
// waiting there while that register still holds an untaken result. A
// clear request sweeps the memory one word per cycle; the same sweep runs
// straight after reset, and in_stall stays high while it runs.
// Configuration writes are taken in any cycle, but should only be issued
// while the block is idle. Words are addressed as column*MAP_ROWS + row;
// the window spans offsets -(c/2) to c-1-(c/2) round the pixel and is
// clipped to the map_width x map_height area.
// ----------------------------------------------------------------------------
module square_window_value_stamp_top #(
  parameter int MAP_COLS   = 64,
  parameter int MAP_ROWS   = 64,
  parameter int MAX_CENTER = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic [swvs_pkg::INDEX_W-1:0]       in_col_index,
  input  logic [swvs_pkg::INDEX_W-1:0]       in_row_index,
  input  logic signed [swvs_pkg::VAL_W-1:0]  in_pixel_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [swvs_pkg::VAL_W-1:0]  out_read_value,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [swvs_pkg::PADDR_W-1:0]       cfg_paddr,
  input  logic [swvs_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [swvs_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                               cfg_pready
);

  localparam int DEPTH = MAP_COLS * MAP_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_CENTER + 1);
  localparam int CRD_W = swvs_pkg::CRD_W;
  localparam int VAL_W = swvs_pkg::VAL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_STAMP,
    ST_READ
  } state_t;

  // word address of a column and row inside the map
  function automatic logic [AW-1:0] map_addr(input logic [CRD_W-2:0] col,
                                             input logic [CRD_W-2:0] row);
    map_addr = AW'(32'(col) * 32'(MAP_ROWS) + 32'(row));
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [swvs_pkg::CSIZE_W-1:0] center_size_r;
  logic [swvs_pkg::BOUND_W-1:0] map_width_r;
  logic [swvs_pkg::BOUND_W-1:0] map_height_r;
  swvs_pkg::reg_idx_t           cfg_idx;
  logic                         cfg_wr;

  assign cfg_idx    = swvs_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_size_r <= swvs_pkg::CENTER_SIZE_RST;
      map_width_r   <= swvs_pkg::MAP_WIDTH_RST;
      map_height_r  <= swvs_pkg::MAP_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        swvs_pkg::REG_CENTER_SIZE: center_size_r <= cfg_pwdata[swvs_pkg::CSIZE_W-1:0];
        swvs_pkg::REG_MAP_WIDTH:   map_width_r   <= cfg_pwdata[swvs_pkg::BOUND_W-1:0];
        swvs_pkg::REG_MAP_HEIGHT:  map_height_r  <= cfg_pwdata[swvs_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      swvs_pkg::REG_CENTER_SIZE: cfg_prdata = swvs_pkg::PDATA_W'(center_size_r);
      swvs_pkg::REG_MAP_WIDTH:   cfg_prdata = swvs_pkg::PDATA_W'(map_width_r);
      swvs_pkg::REG_MAP_HEIGHT:  cfg_prdata = swvs_pkg::PDATA_W'(map_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // request decode
  // --------------------------------------------------------------------------
  state_t                  state_r;
  logic                    in_acc;
  logic [CW-1:0]           ceff;
  logic signed [CRD_W-1:0] cc_start;
  logic signed [CRD_W-1:0] rr_start;
  logic                    val_pos;
  logic                    rd_oor;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // window side, limited to the largest supported size
  assign ceff = (32'(center_size_r) > MAX_CENTER) ? CW'(MAX_CENTER) : CW'(center_size_r);

  // window low corner: offset is minus half the side, rounded down
  assign cc_start = CRD_W'(in_col_index) - CRD_W'(ceff >> 1);
  assign rr_start = CRD_W'(in_row_index) - CRD_W'(ceff >> 1);

  assign val_pos  = (in_pixel_value != '0) && !in_pixel_value[VAL_W-1];
  assign rd_oor   = !((32'(in_col_index) < MAP_COLS) && (32'(in_row_index) < MAP_ROWS));

  assign mem_re    = in_acc && (in_kind == swvs_pkg::KIND_READ);
  assign mem_raddr = map_addr((CRD_W-1)'(in_col_index), (CRD_W-1)'(in_row_index));

  // --------------------------------------------------------------------------
  // stamp window walk
  // --------------------------------------------------------------------------
  logic [CW-1:0]           ceff_r;
  logic [CW-1:0]           a_r;
  logic [CW-1:0]           b_r;
  logic signed [CRD_W-1:0] cc_r;
  logic signed [CRD_W-1:0] rr_r;
  logic signed [CRD_W-1:0] rr_start_r;
  logic [VAL_W-1:0]        val_r;
  logic signed [CRD_W-1:0] wmax;
  logic signed [CRD_W-1:0] hmax;
  logic                    in_map;
  logic [AW-1:0]           clr_addr_r;
  logic                    oor_r;

  // clip bounds, limited to the stored map
  assign wmax = (32'(map_width_r) > MAP_COLS) ? CRD_W'(MAP_COLS) : CRD_W'(map_width_r);
  assign hmax = (32'(map_height_r) > MAP_ROWS) ? CRD_W'(MAP_ROWS) : CRD_W'(map_height_r);

  assign in_map = !cc_r[CRD_W-1] && (cc_r < wmax) && !rr_r[CRD_W-1] && (rr_r < hmax);

  // --------------------------------------------------------------------------
  // map memory
  // --------------------------------------------------------------------------
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [VAL_W-1:0] rd_data_r;
  logic [VAL_W-1:0] mem [DEPTH];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_STAMP) begin
      mem_we    = in_map;
      mem_waddr = map_addr(cc_r[CRD_W-2:0], rr_r[CRD_W-2:0]);
      mem_wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and output register
  // --------------------------------------------------------------------------
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_read_value_r;
  logic                    out_load;

  // read word moves to the output register once that register is free
  assign out_load = (state_r == ST_READ) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // fresh read word loaded, or result taken downstream
      if (out_load) begin
        out_valid_r      <= 1'b1;
        out_read_value_r <= oor_r ? '0 : rd_data_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_kind)
              swvs_pkg::KIND_STAMP: begin
                if (val_pos && (ceff != '0)) begin
                  state_r <= ST_STAMP;
                end
                ceff_r     <= ceff;
                a_r        <= '0;
                b_r        <= '0;
                cc_r       <= cc_start;
                rr_r       <= rr_start;
                rr_start_r <= rr_start;
                val_r      <= in_pixel_value;
              end
              swvs_pkg::KIND_READ: begin
                state_r <= ST_READ;
                oor_r   <= rd_oor;
              end
              swvs_pkg::KIND_CLEAR: begin
                state_r    <= ST_CLEAR;
                clr_addr_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_STAMP: begin
          // rows run fastest, then columns
          if (b_r == ceff_r - 1'b1) begin
            b_r  <= '0;
            rr_r <= rr_start_r;
            a_r  <= a_r + 1'b1;
            cc_r <= cc_r + 1'b1;
            if (a_r == ceff_r - 1'b1) begin
              state_r <= ST_IDLE;
            end
          end else begin
            b_r  <= b_r + 1'b1;
            rr_r <= rr_r + 1'b1;
          end
        end
        ST_READ: begin
          // hold the read word until the output register is free
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;

endmodule

/* hdl/swvs_checker.sv */
// ----------------------------------------------------------------------------
// swvs_checker
// port-level checks for the square window value stamp block
// ----------------------------------------------------------------------------
module swvs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        in_kind,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [swvs_pkg::VAL_W-1:0] out_read_value
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value))
    else $error("result dropped or changed while stalled");

  // map clearing sweep runs straight after reset
  a_reset_sweep: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("request taken during reset clearing sweep");

  // a clear request blocks new requests while it sweeps
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == swvs_pkg::KIND_CLEAR) |=> in_stall)
    else $error("request taken during clear");

  // a read request occupies the block for its memory access
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == swvs_pkg::KIND_READ) |=> in_stall)
    else $error("request taken during read access");

endmodule

bind square_window_value_stamp_top swvs_checker u_swvs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value)
);
